>>> design/vn2_pkg.sv
// Shared constants, types and hash helpers for the 2-D value noise unit.
package vn2_pkg;

    localparam int FRAC_BITS = 16;            // fraction bits of the coordinates, 8..24
    localparam int VAL_W     = 24;            // width of corner values and of the result
    localparam int WGT_W     = VAL_W + 1;     // fade weight, 0 .. 2^24 inclusive
    localparam int PIPE_DEPTH = 9;            // register stages from input to output

    localparam logic [31:0] HASH_C1 = 32'h9E37_79B9;
    localparam logic [31:0] HASH_C2 = 32'h85EB_CA6B;
    localparam logic [31:0] HASH_M1 = 32'h7FEB_352D;
    localparam logic [31:0] HASH_M2 = 32'h846C_A68B;

    // Corner values of one lattice cell.
    typedef struct packed {
        logic [VAL_W-1:0] v00;
        logic [VAL_W-1:0] v10;
        logic [VAL_W-1:0] v01;
        logic [VAL_W-1:0] v11;
    } t_corners;

    // One mixing round: fold a constant and a cell index into the running hash.
    function automatic logic [31:0] mix_round(input logic [31:0] h, input logic [31:0] k,
                                              input logic [31:0] c);
        logic [31:0] sum;
        sum = k + c + (h << 6) + (h >> 2);
        return h ^ sum;
    endfunction

endpackage

>>> design/vn2_hash.sv
// Pipelined seeded hash of the four lattice corners, five register stages.
module vn2_hash (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [31:0]        i_x0,
    input  logic [31:0]        i_x1,
    input  logic [31:0]        i_y0,
    input  logic [31:0]        i_y1,
    input  logic [31:0]        i_seed,
    output vn2_pkg::t_corners  o_corners
);

    // lanes: 0 = (x0,y0), 1 = (x1,y0), 2 = (x0,y1), 3 = (x1,y1)
    logic [31:0] r_h1 [2];
    logic [31:0] r_y0;
    logic [31:0] r_y1;
    logic [31:0] r_h2 [4];
    logic [31:0] r_h3 [4];
    logic [31:0] r_h4 [4];
    logic [vn2_pkg::VAL_W-1:0] r_v [4];

    logic [31:0] n_h2 [4];
    logic [31:0] n_h4 [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            logic [31:0] h;
            h = vn2_pkg::mix_round(r_h1[i % 2], vn2_pkg::HASH_C2, (i < 2) ? r_y0 : r_y1);
            n_h2[i] = h ^ (h >> 16);
            n_h4[i] = r_h3[i] ^ (r_h3[i] >> 15);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h1[0] <= vn2_pkg::mix_round(i_seed, vn2_pkg::HASH_C1, i_x0);
            r_h1[1] <= vn2_pkg::mix_round(i_seed, vn2_pkg::HASH_C1, i_x1);
            r_y0    <= i_y0;
            r_y1    <= i_y1;
            for (int i = 0; i < 4; i++) begin
                logic [31:0] hf;
                hf = r_h4[i] ^ (r_h4[i] >> 16);
                r_h2[i] <= n_h2[i];
                r_h3[i] <= r_h2[i] * vn2_pkg::HASH_M1;
                r_h4[i] <= n_h4[i] * vn2_pkg::HASH_M2;
                r_v[i]  <= hf[vn2_pkg::VAL_W-1:0];
            end
        end
    end

    assign o_corners.v00 = r_v[0];
    assign o_corners.v10 = r_v[1];
    assign o_corners.v01 = r_v[2];
    assign o_corners.v11 = r_v[3];

endmodule

>>> design/vn2_fade.sv
// Smoothstep fade 3t^2 - 2t^3 in Q0.24, padded to five register stages.
module vn2_fade (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [vn2_pkg::VAL_W-1:0]   i_t,
    output logic [vn2_pkg::WGT_W-1:0]   o_weight
);

    localparam logic [47:0] HALF48 = 48'd1 << 23;
    localparam logic [49:0] HALF50 = 50'd1 << 23;
    localparam logic [25:0] THREE_ONE = 26'd3 << 24;
    localparam logic [25:0] ONE26 = 26'd1 << 24;

    logic [47:0] r_tt;
    logic [23:0] r_t;
    logic [49:0] r_p;
    logic [vn2_pkg::WGT_W-1:0] r_s;
    logic [vn2_pkg::WGT_W-1:0] r_s_d1;
    logic [vn2_pkg::WGT_W-1:0] r_s_d2;

    logic [23:0] t2;
    logic [25:0] k;
    logic [25:0] s_raw;

    always_comb begin
        t2    = 24'((r_tt + HALF48) >> 24);
        k     = THREE_ONE - {1'b0, r_t, 1'b0};
        s_raw = 26'((r_p + HALF50) >> 24);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tt   <= 48'(i_t) * 48'(i_t);
            r_t    <= i_t;
            r_p    <= 50'(t2) * 50'(k);
            r_s    <= (s_raw > ONE26) ? ONE26[vn2_pkg::WGT_W-1:0]
                                      : s_raw[vn2_pkg::WGT_W-1:0];
            r_s_d1 <= r_s;
            r_s_d2 <= r_s_d1;
        end
    end

    assign o_weight = r_s_d2;

endmodule

>>> design/vn2_blend.sv
// Bilinear blend of the corner values, three register stages ending in the output register.
module vn2_blend (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  vn2_pkg::t_corners           i_corners,
    input  logic [vn2_pkg::WGT_W-1:0]   i_u,
    input  logic [vn2_pkg::WGT_W-1:0]   i_v,
    output logic [vn2_pkg::VAL_W-1:0]   o_value
);

    // a + round((b - a) * w / 2^24), which equals the two-product form exactly
    function automatic logic [23:0] lerp_fin(input logic [23:0] a,
                                             input logic signed [50:0] m);
        logic signed [50:0] q;
        logic signed [25:0] r;
        q = (m + 51'sd8388608) >>> 24;
        r = $signed(q[25:0]) + $signed({2'b00, a});
        return r[23:0];
    endfunction

    logic signed [50:0] r_m0;
    logic signed [50:0] r_m1;
    logic [23:0] r_a0;
    logic [23:0] r_a1;
    logic [vn2_pkg::WGT_W-1:0] r_v;
    logic signed [50:0] r_m;
    logic [23:0] r_r0;
    logic [23:0] r_out;

    logic signed [24:0] d0;
    logic signed [24:0] d1;
    logic [23:0] r0;
    logic [23:0] r1;
    logic signed [24:0] dr;

    always_comb begin
        d0 = $signed({1'b0, i_corners.v10}) - $signed({1'b0, i_corners.v00});
        d1 = $signed({1'b0, i_corners.v11}) - $signed({1'b0, i_corners.v01});
        r0 = lerp_fin(r_a0, r_m0);
        r1 = lerp_fin(r_a1, r_m1);
        dr = $signed({1'b0, r1}) - $signed({1'b0, r0});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m0  <= 51'(d0) * 51'($signed({1'b0, i_u}));
            r_m1  <= 51'(d1) * 51'($signed({1'b0, i_u}));
            r_a0  <= i_corners.v00;
            r_a1  <= i_corners.v01;
            r_v   <= i_v;
            r_m   <= 51'(dr) * 51'($signed({1'b0, r_v}));
            r_r0  <= r0;
            r_out <= lerp_fin(r_r0, r_m);
        end
    end

    assign o_value = r_out;

endmodule

>>> design/value_noise_2d_unit.sv
// Top level of the 2-D hashed-lattice value noise unit.
// Takes a Q16.16 coordinate pair and a seed and returns one 24-bit noise value per item.
// The unit is a nine-stage pipeline ending in the output register: one item enters
// every cycle while that register is empty or being taken. The depth is set by the
// corner hash (two 32x32 multiplies), run in parallel with the fade multiplies,
// followed by the two blend multiplies. When the output is not taken the whole
// pipeline holds; empty stages are refilled as soon as the output register drains.
module value_noise_2d_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_x_coord,
    input  logic [31:0] i_y_coord,
    input  logic [31:0] i_seed,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [23:0] o_noise_value
);

    logic [vn2_pkg::PIPE_DEPTH-1:0] r_vld;
    logic en;

    logic [31:0] r_x0;
    logic [31:0] r_x1;
    logic [31:0] r_y0;
    logic [31:0] r_y1;
    logic [31:0] r_seed;
    logic [vn2_pkg::VAL_W-1:0] r_tx;
    logic [vn2_pkg::VAL_W-1:0] r_ty;

    logic [31:0] x0;
    logic [31:0] y0;

    vn2_pkg::t_corners corners;
    logic [vn2_pkg::WGT_W-1:0] u;
    logic [vn2_pkg::WGT_W-1:0] v;

    // advance everything while the output register is empty or being taken
    assign en      = !r_vld[vn2_pkg::PIPE_DEPTH-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[vn2_pkg::PIPE_DEPTH-1];

    // cell is the floor of the coordinate
    assign x0 = 32'($signed(i_x_coord) >>> vn2_pkg::FRAC_BITS);
    assign y0 = 32'($signed(i_y_coord) >>> vn2_pkg::FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[vn2_pkg::PIPE_DEPTH-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x0   <= x0;
            r_x1   <= x0 + 32'd1;
            r_y0   <= y0;
            r_y1   <= y0 + 32'd1;
            r_seed <= i_seed;
            r_tx   <= vn2_pkg::VAL_W'(i_x_coord[vn2_pkg::FRAC_BITS-1:0])
                      << (vn2_pkg::VAL_W - vn2_pkg::FRAC_BITS);
            r_ty   <= vn2_pkg::VAL_W'(i_y_coord[vn2_pkg::FRAC_BITS-1:0])
                      << (vn2_pkg::VAL_W - vn2_pkg::FRAC_BITS);
        end
    end

    vn2_hash u_hash (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_x0      (r_x0),
        .i_x1      (r_x1),
        .i_y0      (r_y0),
        .i_y1      (r_y1),
        .i_seed    (r_seed),
        .o_corners (corners)
    );

    vn2_fade u_fade_x (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_t      (r_tx),
        .o_weight (u)
    );

    vn2_fade u_fade_y (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_t      (r_ty),
        .o_weight (v)
    );

    vn2_blend u_blend (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_corners (corners),
        .i_u       (u),
        .i_v       (v),
        .o_value   (o_noise_value)
    );

endmodule
